>>> sv/unordered_set_table_macros.svh
// Assertion helpers for the RTL files.
`ifndef UNORDERED_SET_TABLE_MACROS_SVH
`define UNORDERED_SET_TABLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define UST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define UST_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> sv/ust_pkg.sv
`default_nettype none

package ust_pkg;

  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  localparam int ACT_W = 2;
  localparam int CNT_MAX = (2 ** CNT_W) - 1;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  // slot code for "not present" (-1 in two's complement)
  localparam logic [CNT_W-1:0] POS_NONE = '1;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

endpackage

`default_nettype wire

>>> sv/ust_if.sv
`default_nettype none

interface ust_req_if;
  import ust_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  value_t           value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface ust_rsp_if;
  import ust_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] count;

  modport source (output valid, output ok, output position, output count, input ready);
  modport sink   (input valid, input ok, input position, input count, output ready);
endinterface

`default_nettype wire

>>> sv/ust_table.sv
`default_nettype none

module ust_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ust_pkg::value_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  input  ust_pkg::value_t key_i,
  output ust_pkg::value_t rdata_o,
  output logic            match_o
);
  import ust_pkg::*;

  value_t mem [DEPTH];
  value_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  // bitwise equality over the whole word
  assign match_o = (rdata_q == key_i);

endmodule

`default_nettype wire

>>> sv/unordered_set_table.sv
// Bounded set of signed 32-bit values held as an unordered table plus a count.
// Request channel req_i carries action (lookup, insert, remove) and value;
// response channel rsp_o returns ok, position (slot before the action, or -1)
// and count (entries after the action). One response per request, in order.
// cfg_we_i/cfg_wdata_i write the capacity register; write only while idle.
// The table sits in a single-port-read memory, so a request scans the live
// slots one per cycle from slot 0 until a match or the last slot; a remove
// that finds its value also reads the last entry and moves it into the freed
// slot. A request holds the block until the response register is loaded,
// which waits for the output register to be free, and the next request is
// taken in the cycle after.
// If the receiver stalls, the finished response waits in the output register;
// the next request still runs, and only its own completion waits for the slot.
// Reset: count 0, capacity 64, no response pending. Table contents are not
// cleared; slots at or above the count are never compared.
`default_nettype none

module unordered_set_table #(
  parameter int DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ust_pkg::CNT_W-1:0] cfg_wdata_i,
  ust_req_if.sink                   req_i,
  ust_rsp_if.source                 rsp_o
);
  import ust_pkg::*;

  `include "unordered_set_table_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MOVE = 5'b00100,
    S_DONE = 5'b01000,
    S_HOLD = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  value_t           key_q, key_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cap_q;
  logic             res_ok_q, res_ok_d;
  logic [CNT_W-1:0] res_pos_q, res_pos_d;
  logic [CNT_W-1:0] res_cnt_q, res_cnt_d;

  logic             ovalid_q;
  logic             ook_q;
  logic [CNT_W-1:0] opos_q;
  logic [CNT_W-1:0] ocnt_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  value_t           mem_wdata;
  logic [AW-1:0]    mem_raddr;
  value_t           mem_rdata;
  logic             match;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] idx_nxt;
  logic             hit;
  logic             scan_end;
  logic             out_free;
  logic             load_out;

  ust_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .key_i   (key_q),
    .rdata_o (mem_rdata),
    .match_o (match)
  );

  assign eff_cap  = (cap_q < DEPTH_CAP) ? cap_q : DEPTH_CAP;
  assign idx_nxt  = idx_q + CNT_W'(1);
  assign hit      = (cnt_q != '0) && match;
  assign scan_end = hit || (cnt_q == '0) || (idx_nxt == cnt_q);
  assign out_free = !ovalid_q || rsp_o.ready;
  assign load_out = (state_q == S_DONE) && out_free;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    key_d     = key_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    res_ok_d  = res_ok_q;
    res_pos_d = res_pos_q;
    res_cnt_d = res_cnt_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(cnt_q);
    mem_wdata = key_q;
    // keep the read one slot ahead of the compare
    mem_raddr = AW'(idx_nxt);

    unique case (state_q)
      S_IDLE: begin
        mem_raddr = '0;
        if (req_i.valid) begin
          act_d   = req_i.action;
          key_d   = req_i.value;
          idx_d   = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          res_pos_d = hit ? idx_q : POS_NONE;
          res_ok_d  = 1'b0;
          res_cnt_d = cnt_q;
          state_d   = S_DONE;
          case (act_q)
            ACT_LOOKUP: res_ok_d = hit;
            ACT_INSERT: begin
              if (hit) begin
                res_ok_d = 1'b1;
              end else if (cnt_q < eff_cap) begin
                mem_we    = 1'b1;
                cnt_d     = cnt_q + CNT_W'(1);
                res_cnt_d = cnt_q + CNT_W'(1);
                res_ok_d  = 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                // fetch the last entry to fill the hole
                mem_raddr = AW'(cnt_q - CNT_W'(1));
                state_d   = S_MOVE;
              end
            end
            default: ;
          endcase
        end else begin
          idx_d = idx_nxt;
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_q);
        mem_wdata = mem_rdata;
        cnt_d     = cnt_q - CNT_W'(1);
        res_cnt_d = cnt_q - CNT_W'(1);
        res_ok_d  = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_HOLD: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      cap_q    <= CAP_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    res_ok_q  <= res_ok_d;
    res_pos_q <= res_pos_d;
    res_cnt_q <= res_cnt_d;
    if (load_out) begin
      ook_q  <= res_ok_q;
      opos_q <= res_pos_q;
      ocnt_q <= res_cnt_q;
    end
  end

  assign rsp_o.valid    = ovalid_q;
  assign rsp_o.ok       = ook_q;
  assign rsp_o.position = opos_q;
  assign rsp_o.count    = ocnt_q;

  // count may still be unknown at the first edge of reset
  `UST_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || cnt_q <= DEPTH_CAP, "fill count above table size")
  `UST_ASSERT(a_accept_scans, req_i.valid && req_i.ready |=> state_q == S_SCAN,
              "accepted request did not start a scan")
  `UST_ASSERT(a_cnt_change, !$stable(cnt_q) |-> $past(state_q) == S_SCAN ||
              $past(state_q) == S_MOVE, "count changed outside an update")
  `UST_ASSERT(a_rsp_source, $rose(rsp_o.valid) |-> $past(state_q) == S_DONE,
              "response raised without a finished request")

endmodule

`default_nettype wire

>>> sim/testbench.sv
`default_nettype none

module testbench;
  import ust_pkg::*;

  localparam int SET_DEPTH = 64;
  // action code with no meaning: leaves the table alone
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int RUN_LIMIT = 40_000_000;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } reply_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  ust_req_if req ();
  ust_rsp_if rsp ();

  unordered_set_table #(
    .DEPTH(SET_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // shadow copy of the set
  value_t     set_slots [SET_DEPTH];
  int         set_count;
  int         set_cap;
  reply_t     owed_replies[$];
  value_t     value_pool[$];
  int         mismatches;
  bit         gaps_on;
  int         rx_hold;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // apply one request to the shadow set and return the reply it owes
  function automatic reply_t run_set_op(logic [ACT_W-1:0] act, value_t val);
    reply_t r;
    int     slot;
    int     lim;
    slot = -1;
    for (int i = 0; i < set_count; i++)
      if (slot < 0 && set_slots[i] == val) slot = i;
    lim  = (set_cap < SET_DEPTH) ? set_cap : SET_DEPTH;
    r.ok = 1'b0;
    case (act)
      ACT_LOOKUP: r.ok = (slot >= 0);
      ACT_INSERT: begin
        if (slot >= 0) begin
          r.ok = 1'b1;
        end else if (set_count < lim) begin
          set_slots[set_count] = val;
          set_count++;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (slot >= 0) begin
          set_count--;
          set_slots[slot] = set_slots[set_count];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.pos = (slot < 0) ? POS_NONE : slot[CNT_W-1:0];
    r.cnt = set_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic send_req(input logic [ACT_W-1:0] act, input value_t val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.value  <= val;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    owed_replies.push_back(run_set_op(act, val));
  endtask

  task automatic wait_drain();
    int n;
    n = 0;
    req.valid <= 1'b0;
    while (owed_replies.size() > 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic write_capacity(input int c);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    set_cap = c;
  endtask

  // pool keeps the current members so removes and repeats hit often
  task automatic refill_pool(input int n);
    value_pool.delete();
    for (int i = 0; i < set_count; i++) value_pool.push_back(set_slots[i]);
    value_pool.push_back(32'h0000_0000);
    value_pool.push_back(32'h7FFF_FFFF);
    value_pool.push_back(32'h8000_0000);
    value_pool.push_back(32'hFFFF_FFFF);
    repeat (n) value_pool.push_back($urandom);
  endtask

  function automatic value_t pick_value();
    if ($urandom_range(0, 99) < 85)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return ACT_SPARE;
    if (r < 5 + ins_pct) return ACT_INSERT;
    if (r < 5 + ins_pct + (95 - ins_pct) / 2) return ACT_LOOKUP;
    return ACT_REMOVE;
  endfunction

  task automatic random_phase(input int cap, input int items, input int pool_n,
                              input int ins_pct);
    write_capacity(cap);
    refill_pool(pool_n);
    repeat (items) send_req(pick_action(ins_pct), pick_value());
  endtask

  task automatic test_edge_values();
    send_req(ACT_LOOKUP, 32'h0000_0000);
    send_req(ACT_REMOVE, 32'h0000_0005);
    send_req(ACT_INSERT, 32'h7FFF_FFFF);
    send_req(ACT_INSERT, 32'h8000_0000);
    send_req(ACT_INSERT, 32'h0000_0000);
    send_req(ACT_INSERT, 32'hFFFF_FFFF);
    send_req(ACT_INSERT, 32'h0000_0001);
    // differs from the one above only in the sign bit
    send_req(ACT_INSERT, 32'h8000_0001);
    send_req(ACT_INSERT, 32'h0000_0000);
    send_req(ACT_LOOKUP, 32'h8000_0001);
    send_req(ACT_LOOKUP, 32'hFFFF_FFFE);
    send_req(ACT_SPARE,  32'h0000_0000);
    send_req(ACT_SPARE,  32'h1234_5678);
    // first slot freed, last entry swapped in
    send_req(ACT_REMOVE, 32'h7FFF_FFFF);
    send_req(ACT_REMOVE, 32'h8000_0001);
    // removing the last entry itself
    send_req(ACT_REMOVE, 32'hFFFF_FFFF);
    send_req(ACT_REMOVE, 32'hFFFF_FFFF);
    send_req(ACT_INSERT, 32'hAAAA_AAAA);
    send_req(ACT_INSERT, 32'h5555_5555);
  endtask

  task automatic test_capacity_limits();
    write_capacity(0);
    send_req(ACT_INSERT, 32'h0000_1234);
    send_req(ACT_INSERT, 32'h0000_0000);
    // capacity now below the count: members stay, new values bounce
    write_capacity(3);
    send_req(ACT_INSERT, 32'h0000_1234);
    send_req(ACT_REMOVE, 32'h0000_0001);
    send_req(ACT_REMOVE, 32'h8000_0000);
    send_req(ACT_INSERT, 32'h0000_1234);
    send_req(ACT_REMOVE, 32'h0000_0000);
    send_req(ACT_INSERT, 32'h0000_1234);
  endtask

  task automatic test_random_mix();
    random_phase(127, 220, 90, 70);  // past the table size: fills to DEPTH
    random_phase(64, 160, 70, 40);
    random_phase(1, 120, 20, 35);
    random_phase(5, 130, 20, 40);
    random_phase(0, 100, 30, 35);
    random_phase(40, 160, 50, 45);
    random_phase(16, 150, 30, 40);
    random_phase(64, 150, 80, 55);
  endtask

  task automatic test_backpressure();
    write_capacity(8);
    refill_pool(12);
    rx_hold = 400;
    repeat (30) send_req(pick_action(50), pick_value());
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    random_phase(20, 100, 25, 45);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // response side: random stalls, plus a long hold when asked
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        rsp.ready <= 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
        if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with none owed: ok %0b pos %0d count %0d", $time,
                 rsp.ok, $signed(rsp.position), rsp.count);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (rsp.ok !== want.ok || rsp.position !== want.pos || rsp.count !== want.cnt) begin
          $display("%0t: reply mismatch: expected ok %0b pos %0d count %0d, got ok %0b pos %0d count %0d",
                   $time, want.ok, $signed(want.pos), want.cnt,
                   rsp.ok, $signed(rsp.position), rsp.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    gaps_on    = 1'b1;
    rx_hold    = 0;
    set_count  = 0;
    set_cap    = CAP_RESET;
    rst_ni     = 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    req.valid  <= 1'b0;
    req.action <= ACT_LOOKUP;
    req.value  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_edge_values();
    test_capacity_limits();
    test_random_mix();
    test_backpressure();
    test_back_to_back();

    wait_drain();
    repeat (80) @(posedge clk_i);
    if (owed_replies.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, owed_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
